[rtl/core/weighted_union_find_mod3_unit_macros.svh]
// Assertion macros used by the checker of the union-find block.
// No dependencies; include by bare file name.
`ifndef WEIGHTED_UNION_FIND_MOD3_UNIT_MACROS_SVH
`define WEIGHTED_UNION_FIND_MOD3_UNIT_MACROS_SVH

// Clocked assertion, quiet while reset is asserted.
`define WUF_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("union-find check failed");

// Clocked assertion that also holds across reset.
`define WUF_ASSERT_NR(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("union-find reset check failed");

`endif

[rtl/core/wufm3_pkg.sv]
// Package for the weighted union-find block: widths, defaults, mod-3 helpers.
// No dependencies.
package wufm3_pkg;

    localparam int MAX_ELEMENTS_DEF = 65536;
    localparam int IDX_IN_W         = 16;
    localparam int COUNT_W          = 32;
    localparam int S_TDATA_W        = 32;
    localparam int M_TDATA_W        = 40;

    localparam logic [IDX_IN_W-1:0] ELEMENT_COUNT_RST = 16'hFFFF;
    localparam logic [COUNT_W-1:0]  COUNT_MAX         = 32'hFFFF_FFFF;

    // operands kept in 0..2
    function automatic logic [1:0] add3(input logic [1:0] x, input logic [1:0] y);
        logic [2:0] s;
        s = {1'b0, x} + {1'b0, y};
        add3 = (s >= 3'd3) ? 2'(s - 3'd3) : s[1:0];
    endfunction

    function automatic logic [1:0] sub3(input logic [1:0] x, input logic [1:0] y);
        logic [2:0] s;
        s = {1'b0, x} + 3'd3 - {1'b0, y};
        sub3 = (s >= 3'd3) ? 2'(s - 3'd3) : s[1:0];
    endfunction

endpackage

[rtl/core/weighted_union_find_mod3_unit.sv]
// Top level of the weighted union-find block with mod-3 offsets.
// Depends on wufm3_pkg and wufm3_ram.
//
//  channel  | dir | handshake         | content
//  s_*      | in  | s_tvalid/s_tready | tuser: command; tdata: first, second index
//  m_*      | out | m_tvalid/m_tready | tdata: statement_false, false_count
//  cfg_*    | in  | cfg_we            | element_count
//
// Each find walks the chain one memory read per cycle, then rewrites it one
// entry per cycle, bound by the one read port of the parent/offset RAM.
// An out-of-range statement skips the walk. After reset a clearing pass
// sets every entry to itself; no beat is taken meanwhile. One result waits
// in the output register while the next statement is worked on.
module weighted_union_find_mod3_unit #(
    parameter int MAX_ELEMENTS = wufm3_pkg::MAX_ELEMENTS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic                            s_tuser,   // [0] command
    input  logic [wufm3_pkg::S_TDATA_W-1:0] s_tdata,   // [15:0] first_index, [31:16] second_index
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [wufm3_pkg::M_TDATA_W-1:0] m_tdata,   // [0] statement_false, [32:1] false_count
    input  logic                            cfg_we,
    input  logic [wufm3_pkg::IDX_IN_W-1:0]  cfg_wdata
);

    localparam int IDX_W = $clog2(MAX_ELEMENTS);
    localparam int ENT_W = IDX_W + 2;
    localparam logic [31:0]      IDX_LIMIT = 32'(MAX_ELEMENTS);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(MAX_ELEMENTS - 1);

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_WALK  = 6'b000100,
        ST_FIX   = 6'b001000,
        ST_JOIN  = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic [IDX_W-1:0] clr_reg, clr_next;
    logic [wufm3_pkg::IDX_IN_W-1:0] elem_count_reg;
    logic rel_reg, rel_next;
    logic [IDX_W-1:0] a_reg, a_next, b_reg, b_next;
    logic phase_reg, phase_next;
    logic [IDX_W-1:0] cur_reg, cur_next, root_reg, root_next, ra_reg, ra_next;
    logic [1:0] sum_reg, sum_next, tot_reg, tot_next, da_reg, da_next;
    logic bad_reg, bad_next;
    logic m_tvalid_reg, m_tvalid_next;
    logic [wufm3_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [wufm3_pkg::COUNT_W-1:0] false_cnt_reg, false_cnt_next;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr, ram_raddr;
    logic [ENT_W-1:0] ram_wdata, ram_rdata;
    logic [IDX_W-1:0] rd_parent;
    logic [1:0]       rd_off;

    logic [wufm3_pkg::IDX_IN_W-1:0] in_a, in_b;
    logic in_ok;
    logic [IDX_W-1:0] node;

    assign rd_parent = ram_rdata[ENT_W-1:2];
    assign rd_off    = ram_rdata[1:0];
    assign in_a      = s_tdata[15:0];
    assign in_b      = s_tdata[31:16];
    assign in_ok     = (in_a != '0) && (in_b != '0)
                    && (in_a <= elem_count_reg) && (in_b <= elem_count_reg)
                    && (32'(in_a) < IDX_LIMIT) && (32'(in_b) < IDX_LIMIT);
    assign node      = phase_reg ? b_reg : a_reg;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    wufm3_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_ELEMENTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        rel_next       = rel_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        phase_next     = phase_reg;
        cur_next       = cur_reg;
        root_next      = root_reg;
        ra_next        = ra_reg;
        sum_next       = sum_reg;
        tot_next       = tot_reg;
        da_next        = da_reg;
        bad_next       = bad_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        false_cnt_next = false_cnt_reg;
        ram_we         = 1'b0;
        ram_waddr      = cur_reg;
        ram_wdata      = {root_reg, sum_reg};
        ram_raddr      = cur_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = {clr_reg, 2'b00};
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == LAST_IDX)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    rel_next = s_tuser;
                    if (!in_ok)
                    begin
                        bad_next   = 1'b1;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        a_next     = IDX_W'(in_a);
                        b_next     = IDX_W'(in_b);
                        cur_next   = IDX_W'(in_a);
                        ram_raddr  = IDX_W'(in_a);
                        sum_next   = 2'd0;
                        phase_next = 1'b0;
                        state_next = ST_WALK;
                    end
                end
            end
            ST_WALK:
            begin
                if (rd_parent == cur_reg)
                begin
                    root_next = cur_reg;
                    tot_next  = sum_reg;
                    if (node != cur_reg)
                    begin
                        // second pass: rewrite the path from the start node
                        cur_next   = node;
                        ram_raddr  = node;
                        state_next = ST_FIX;
                    end
                    else if (!phase_reg)
                    begin
                        ra_next    = cur_reg;
                        da_next    = sum_reg;
                        phase_next = 1'b1;
                        cur_next   = b_reg;
                        ram_raddr  = b_reg;
                        sum_next   = 2'd0;
                    end
                    else
                    begin
                        state_next = ST_JOIN;
                    end
                end
                else
                begin
                    sum_next  = wufm3_pkg::add3(sum_reg, rd_off);
                    cur_next  = rd_parent;
                    ram_raddr = rd_parent;
                end
            end
            ST_FIX:
            begin
                if (cur_reg == root_reg)
                begin
                    if (!phase_reg)
                    begin
                        ra_next    = root_reg;
                        da_next    = tot_reg;
                        phase_next = 1'b1;
                        cur_next   = b_reg;
                        ram_raddr  = b_reg;
                        sum_next   = 2'd0;
                        state_next = ST_WALK;
                    end
                    else
                    begin
                        state_next = ST_JOIN;
                    end
                end
                else
                begin
                    ram_we    = 1'b1;
                    ram_waddr = cur_reg;
                    ram_wdata = {root_reg, sum_reg};
                    sum_next  = wufm3_pkg::sub3(sum_reg, rd_off);
                    cur_next  = rd_parent;
                    ram_raddr = rd_parent;
                end
            end
            ST_JOIN:
            begin
                // root_reg/tot_reg hold the second root and offset
                if (ra_reg == root_reg)
                begin
                    bad_next = (wufm3_pkg::sub3(da_reg, tot_reg) != {1'b0, rel_reg});
                end
                else
                begin
                    bad_next  = 1'b0;
                    ram_we    = 1'b1;
                    ram_waddr = ra_reg;
                    ram_wdata = {root_reg,
                                 wufm3_pkg::sub3(wufm3_pkg::add3(tot_reg, {1'b0, rel_reg}),
                                                 da_reg)};
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    if (bad_reg && (false_cnt_reg != wufm3_pkg::COUNT_MAX))
                    begin
                        false_cnt_next = false_cnt_reg + 1'b1;
                    end
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = wufm3_pkg::M_TDATA_W'({false_cnt_next, bad_reg});
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_reg        <= '0;
            elem_count_reg <= wufm3_pkg::ELEMENT_COUNT_RST;
            phase_reg      <= 1'b0;
            bad_reg        <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            false_cnt_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            phase_reg     <= phase_next;
            bad_reg       <= bad_next;
            m_tvalid_reg  <= m_tvalid_next;
            false_cnt_reg <= false_cnt_next;
            if (cfg_we)
            begin
                elem_count_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rel_reg     <= rel_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        cur_reg     <= cur_next;
        root_reg    <= root_next;
        ra_reg      <= ra_next;
        sum_reg     <= sum_next;
        tot_reg     <= tot_next;
        da_reg      <= da_next;
        m_tdata_reg <= m_tdata_next;
    end

endmodule

[rtl/core/wufm3_ram.sv]
// Generic single-clock RAM, one write port, one read port, registered read.
// No dependencies.
module wufm3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/core/wufm3_checker.sv]
// Port-level checks for the union-find block, bound to the top level.
// Depends on wufm3_pkg and weighted_union_find_mod3_unit_macros.svh.
`include "weighted_union_find_mod3_unit_macros.svh"

module wufm3_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [wufm3_pkg::M_TDATA_W-1:0] m_tdata
);

    // a held result keeps its beat
    `WUF_ASSERT(a_out_hold, clk, rst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    // one statement at a time: busy right after a beat is taken
    `WUF_ASSERT(a_in_busy, clk, rst_n, s_tvalid && s_tready |=> !s_tready)
    // a false statement is always reflected in the count
    `WUF_ASSERT(a_cnt_nz, clk, rst_n, m_tvalid && m_tdata[0] |-> m_tdata[32:1] != 32'd0)
    // leaving reset: nothing on offer, clearing pass still running
    `WUF_ASSERT_NR(a_rst_quiet, clk, $rose(rst_n) |-> !m_tvalid && !s_tready)

endmodule

bind weighted_union_find_mod3_unit wufm3_checker u_wufm3_checker (.*);
